// ===== hw/rtl/aes_pkg.sv =====
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam logic [7:0] KeyHighIdx = 8'd0;
  localparam logic [7:0] KeyLowIdx = 8'd1;
  localparam logic [3:0] KeySettleCycles = 4'(NumRounds + 1);

  typedef struct packed {
    logic        kind;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_word_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_word_t;

  typedef struct packed {
    logic         valid;
    logic         kind;
    logic [127:0] state;
  } stage_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    gmul = p;
  endfunction

  // The inverse is a to the power 254, which also maps zero to zero.
  function automatic logic [7:0] inv8(input logic [7:0] a);
    logic [7:0] r;
    r = a;
    for (int i = 0; i < 6; i++) r = gmul(gmul(r, r), a);
    inv8 = gmul(r, r);
  endfunction

  function automatic logic [2047:0] make_sbox(input logic inverse);
    logic [2047:0] t;
    logic [7:0] v;
    logic [7:0] s;
    t = '0;
    for (int x = 0; x < 256; x++) begin
      v = inv8(8'(x));
      s = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]} ^ {v[3:0], v[7:4]}
        ^ 8'h63;
      if (inverse) t[{s, 3'b000} +: 8] = 8'(x);
      else t[{8'(x), 3'b000} +: 8] = s;
    end
    make_sbox = t;
  endfunction

  localparam logic [2047:0] SboxTab = make_sbox(1'b0);
  localparam logic [2047:0] IsboxTab = make_sbox(1'b1);

  function automatic logic [7:0] sbox_lut(input logic [7:0] x);
    sbox_lut = SboxTab[{x, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] isbox_lut(input logic [7:0] x);
    isbox_lut = IsboxTab[{x, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] byte_of(input logic [127:0] s, input int i);
    byte_of = s[127 - 8 * i -: 8];
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    logic [7:0] b [16];
    logic [7:0] o [16];
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = sbox_lut(byte_of(s, i));
    for (int c = 0; c < 4; c++)
      for (int rw = 0; rw < 4; rw++) o[4 * c + rw] = b[rw + 4 * ((c + rw) & 3)];
    for (int c = 0; c < 4; c++) begin
      if (!last) begin
        b[4*c]   = xt(o[4*c]) ^ xt(o[4*c+1]) ^ o[4*c+1] ^ o[4*c+2] ^ o[4*c+3];
        b[4*c+1] = o[4*c] ^ xt(o[4*c+1]) ^ xt(o[4*c+2]) ^ o[4*c+2] ^ o[4*c+3];
        b[4*c+2] = o[4*c] ^ o[4*c+1] ^ xt(o[4*c+2]) ^ xt(o[4*c+3]) ^ o[4*c+3];
        b[4*c+3] = xt(o[4*c]) ^ o[4*c] ^ o[4*c+1] ^ o[4*c+2] ^ xt(o[4*c+3]);
      end else begin
        for (int rw = 0; rw < 4; rw++) b[4*c+rw] = o[4*c+rw];
      end
    end
    for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = b[i];
    enc_round = r ^ k;
  endfunction

  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    logic [7:0] b [16];
    logic [7:0] o [16];
    logic [7:0] a [4];
    logic [127:0] r;
    for (int i = 0; i < 16; i++) o[i] = byte_of(s, i);
    for (int i = 0; i < 16; i++) b[i] = o[i];
    for (int c = 0; c < 4; c++)
      for (int rw = 1; rw < 4; rw++) b[rw + 4 * ((c + rw) & 3)] = o[rw + 4 * c];
    for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = isbox_lut(b[i]) ^ byte_of(k, i);
    if (!last) begin
      for (int i = 0; i < 16; i++) o[i] = byte_of(r, i);
      for (int c = 0; c < 4; c++) begin
        for (int rw = 0; rw < 4; rw++) a[rw] = o[4 * c + rw];
        for (int rw = 0; rw < 4; rw++)
          b[4 * c + rw] = gmul(a[rw], 8'h0e) ^ gmul(a[(rw + 1) & 3], 8'h0b)
                        ^ gmul(a[(rw + 2) & 3], 8'h0d) ^ gmul(a[(rw + 3) & 3], 8'h09);
      end
      for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = b[i];
    end
    dec_round = r;
  endfunction

  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w [4];
    logic [31:0] t;
    logic [127:0] r;
    for (int i = 0; i < 4; i++) w[i] = k[127 - 32 * i -: 32];
    t = {sbox_lut(w[3][23:16]) ^ rc, sbox_lut(w[3][15:8]), sbox_lut(w[3][7:0]),
         sbox_lut(w[3][31:24])};
    w[0] = w[0] ^ t;
    w[1] = w[1] ^ w[0];
    w[2] = w[2] ^ w[1];
    w[3] = w[3] ^ w[2];
    r = {w[0], w[1], w[2], w[3]};
    next_key = r;
  endfunction

endpackage

// ===== hw/rtl/aes128_block_cipher_top.sv =====
// One AES-128 block enters per cycle while in_ready is high and passes through a registered
// first key addition followed by a row of ten registered round cells to the output word;
// the pipeline stalls as a whole when the output word is not taken.
// The round keys ripple from the key registers through their own chain of eleven registers,
// so after reset and after every key write the input is held off until that chain has settled.
module aes128_block_cipher_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  aes_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output aes_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  logic [63:0] key_high;
  logic [63:0] key_low;
  logic [127:0] sched_keys [aes_pkg::NumRounds + 1];
  aes_pkg::stage_t stage [aes_pkg::NumRounds + 1];
  logic en;
  logic [3:0] settle;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
    end else if (cfg_we) begin
      if (cfg_index == aes_pkg::KeyHighIdx) key_high <= cfg_data;
      if (cfg_index == aes_pkg::KeyLowIdx) key_low <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      settle <= aes_pkg::KeySettleCycles;
    end else if (settle != '0) begin
      settle <= settle - 4'd1;
    end
  end

  aes_key_sched u_sched (
    .clk(clk),
    .key({key_high, key_low}),
    .keys(sched_keys)
  );

  assign en = !stage[aes_pkg::NumRounds].valid || out_ready;
  assign in_ready = en && (settle == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage[0].valid <= 1'b0;
    end else if (en) begin
      stage[0].valid <= in_valid && in_ready;
    end
    if (en) begin
      stage[0].kind <= in_data.kind;
      stage[0].state <= {in_data.block_high, in_data.block_low}
                      ^ (in_data.kind ? sched_keys[aes_pkg::NumRounds] : sched_keys[0]);
    end
  end

  for (genvar g = 1; g <= aes_pkg::NumRounds; g++) begin : g_cell
    aes_round_cell u_cell (
      .clk(clk),
      .rst(rst),
      .en(en),
      .last(g == aes_pkg::NumRounds),
      .enc_key(sched_keys[g]),
      .dec_key(sched_keys[aes_pkg::NumRounds - g]),
      .prev(stage[g - 1]),
      .cur(stage[g])
    );
  end

  assign out_valid = stage[aes_pkg::NumRounds].valid;
  assign out_data = {stage[aes_pkg::NumRounds].state[127:64],
                     stage[aes_pkg::NumRounds].state[63:0]};

  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == ((!out_valid || out_ready) && settle == '0)) else $error("ready mismatch");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("output lost");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    en && stage[aes_pkg::NumRounds - 1].valid |=> out_valid) else $error("word dropped");

endmodule

// ===== hw/rtl/aes_key_sched.sv =====
module aes_key_sched (
  input  logic         clk,
  input  logic [127:0] key,
  output logic [127:0] keys [aes_pkg::NumRounds + 1]
);

  logic [7:0] rc [aes_pkg::NumRounds];

  always_comb begin
    rc[0] = 8'h01;
    for (int i = 1; i < aes_pkg::NumRounds; i++) rc[i] = aes_pkg::xt(rc[i - 1]);
  end

  always_ff @(posedge clk) begin
    keys[0] <= key;
    for (int i = 1; i <= aes_pkg::NumRounds; i++)
      keys[i] <= aes_pkg::next_key(keys[i - 1], rc[i - 1]);
  end

endmodule

// ===== hw/rtl/aes_round_cell.sv =====
module aes_round_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            last,
  input  logic [127:0]    enc_key,
  input  logic [127:0]    dec_key,
  input  aes_pkg::stage_t prev,
  output aes_pkg::stage_t cur
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (en) begin
      cur.valid <= prev.valid;
    end
    if (en) begin
      cur.kind <= prev.kind;
      cur.state <= prev.kind ? aes_pkg::dec_round(prev.state, dec_key, last)
                             : aes_pkg::enc_round(prev.state, enc_key, last);
    end
  end

endmodule

// ===== test/aes128_block_cipher_top_test.sv =====
`timescale 1ns / 1ps

module aes128_block_cipher_top_test;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  aes_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  aes_pkg::out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [7:0] fwd_sbox [256];
  logic [7:0] rev_sbox [256];
  logic [127:0] active_key = '0;
  aes_pkg::out_word_t expected_blocks [$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit no_stall = 1'b0;
  bit sender_bursty = 1'b1;
  int burst_left = 0;

  localparam int WatchdogLimit = 20000;

  aes128_block_cipher_top u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [7:0] times2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] field_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = times2(a);
    end
    return acc;
  endfunction

  task automatic build_sboxes();
    logic [7:0] inv;
    logic [7:0] s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++)
        if (field_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
        ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_sbox[x] = s;
      rev_sbox[s] = 8'(x);
    end
  endtask

  function automatic aes_pkg::out_word_t aes_transform(input aes_pkg::in_word_t w);
    logic [7:0] rk [176];
    logic [7:0] st [16];
    logic [7:0] o [16];
    logic [7:0] t [4];
    logic [7:0] rc;
    logic [7:0] tmp;
    logic [127:0] flat;
    aes_pkg::out_word_t res;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) rk[i] = active_key[127 - 8 * i -: 8];
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) t[j] = rk[4 * (i - 1) + j];
      if ((i & 3) == 0) begin
        tmp = t[0];
        t[0] = fwd_sbox[t[1]] ^ rc;
        t[1] = fwd_sbox[t[2]];
        t[2] = fwd_sbox[t[3]];
        t[3] = fwd_sbox[tmp];
        rc = times2(rc);
      end
      for (int j = 0; j < 4; j++) rk[4 * i + j] = rk[4 * (i - 4) + j] ^ t[j];
    end
    flat = {w.block_high, w.block_low};
    for (int i = 0; i < 16; i++) st[i] = flat[127 - 8 * i -: 8];
    if (!w.kind) begin
      for (int i = 0; i < 16; i++) st[i] ^= rk[i];
      for (int r = 1; r <= 10; r++) begin
        for (int i = 0; i < 16; i++) o[i] = fwd_sbox[st[i]];
        for (int c = 0; c < 4; c++)
          for (int rw = 0; rw < 4; rw++) st[rw + 4 * c] = o[rw + 4 * ((c + rw) & 3)];
        if (r < 10) begin
          o = st;
          for (int c = 0; c < 4; c++)
            for (int rw = 0; rw < 4; rw++)
              st[4 * c + rw] = field_mul(o[4 * c + rw], 8'h02)
                ^ field_mul(o[4 * c + ((rw + 1) & 3)], 8'h03)
                ^ o[4 * c + ((rw + 2) & 3)] ^ o[4 * c + ((rw + 3) & 3)];
        end
        for (int i = 0; i < 16; i++) st[i] ^= rk[16 * r + i];
      end
    end else begin
      for (int i = 0; i < 16; i++) st[i] ^= rk[160 + i];
      for (int r = 9; r >= 0; r--) begin
        o = st;
        for (int c = 0; c < 4; c++)
          for (int rw = 0; rw < 4; rw++) st[rw + 4 * ((c + rw) & 3)] = o[rw + 4 * c];
        for (int i = 0; i < 16; i++) st[i] = rev_sbox[st[i]] ^ rk[16 * r + i];
        if (r > 0) begin
          o = st;
          for (int c = 0; c < 4; c++)
            for (int rw = 0; rw < 4; rw++)
              st[4 * c + rw] = field_mul(o[4 * c + rw], 8'h0e)
                ^ field_mul(o[4 * c + ((rw + 1) & 3)], 8'h0b)
                ^ field_mul(o[4 * c + ((rw + 2) & 3)], 8'h0d)
                ^ field_mul(o[4 * c + ((rw + 3) & 3)], 8'h09);
        end
      end
    end
    for (int i = 0; i < 16; i++) flat[127 - 8 * i -: 8] = st[i];
    res.result_high = flat[127:64];
    res.result_low = flat[63:0];
    return res;
  endfunction

  function automatic logic [63:0] random_word();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_block(input logic kind, input logic [63:0] hi, input logic [63:0] lo);
    aes_pkg::in_word_t w;
    int gap;
    w.kind = kind;
    w.block_high = hi;
    w.block_low = lo;
    if (sender_bursty) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    expected_blocks.push_back(aes_transform(w));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_blocks.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= aes_pkg::KeyHighIdx;
    cfg_data <= hi;
    @(negedge clk);
    cfg_index <= aes_pkg::KeyLowIdx;
    cfg_data <= lo;
    @(negedge clk);
    cfg_index <= 8'd2 + 8'($urandom_range(0, 253));
    cfg_data <= random_word();
    @(negedge clk);
    cfg_we <= 1'b0;
    active_key = {hi, lo};
    repeat (3) @(negedge clk);
  endtask

  task automatic test_reset_key();
    send_block(1'b0, '0, '0);
    send_block(1'b1, '0, '0);
    send_block(1'b0, '1, '1);
    send_block(1'b1, '1, '1);
  endtask

  task automatic test_standard_vectors();
    write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    write_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    send_block(1'b0, 64'h3243f6a8885a308d, 64'h313198a2e0370734);
    send_block(1'b1, 64'h3925841d02dc09fb, 64'hdc118597196a0b32);
  endtask

  task automatic test_key_extremes();
    write_key('1, '1);
    for (int i = 0; i < 6; i++) send_block(1'(i), i[1] ? '1 : '0, i[2] ? '1 : '0);
    send_block(1'b0, 64'h8000000000000000, 64'h0000000000000001);
    send_block(1'b1, 64'h0000000000000001, 64'h8000000000000000);
    write_key(64'h8000000000000000, 64'h1);
    send_block(1'b0, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    send_block(1'b1, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
  endtask

  task automatic test_random_stream();
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 5) write_key('0, '0);
      else write_key(random_word(), random_word());
      no_stall = (phase == 2);
      sender_bursty = (phase != 3);
      for (int i = 0; i < 220; i++) send_block(1'($urandom()), random_word(), random_word());
    end
    no_stall = 1'b0;
  endtask

  task automatic test_back_pressure();
    write_key(random_word(), random_word());
    sender_bursty = 1'b0;
    hold_off = 1'b1;
    for (int i = 0; i < 30; i++) send_block(1'($urandom()), random_word(), random_word());
    sender_bursty = 1'b1;
  endtask

  always @(negedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
    end else if (no_stall) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 9) < 7);
    end
  end

  initial begin
    int n;
    wait (!rst);
    forever begin
      wait (hold_off);
      n = 0;
      while (n < 60) begin
        @(negedge clk);
        n++;
      end
      hold_off = 1'b0;
    end
  end

  always @(posedge clk) begin
    aes_pkg::out_word_t exp_w;
    if (!rst && out_valid && out_ready) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected output word %h", $time, out_data);
        errors++;
      end else begin
        exp_w = expected_blocks.pop_front();
        if (out_data.result_high !== exp_w.result_high) begin
          $display("%0t: result_high expected %h actual %h", $time, exp_w.result_high,
                   out_data.result_high);
          errors++;
        end
        if (out_data.result_low !== exp_w.result_low) begin
          $display("%0t: result_low expected %h actual %h", $time, exp_w.result_low,
                   out_data.result_low);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchdogLimit) begin
        $display("aes128_block_cipher_top_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    build_sboxes();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_key();
    test_standard_vectors();
    test_key_extremes();
    test_back_pressure();
    test_random_stream();
    drain();
    repeat (20) @(negedge clk);
    if (errors == 0 && expected_blocks.size() == 0) begin
      $display("aes128_block_cipher_top_test OK");
    end else begin
      $display("aes128_block_cipher_top_test NOT OK");
    end
    $finish;
  end

endmodule
